// ===== hw/rtl/csic_pkg.sv =====
// Shared field widths, register map and mode codes of the color sort intake controller.
`default_nettype none

package csic_pkg;

	// Field widths
	localparam int TIME_W   = 32;
	localparam int HUE_W    = 9;
	localparam int WIN_W    = 8;
	localparam int DUR_W    = 16;
	localparam int SPEED_W  = 7;
	localparam int MODE_W   = 2;
	localparam int POWER_W  = 8;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_RED_HUE_REF  = 3'd0;
	localparam logic [2:0] REG_BLUE_HUE_REF = 3'd1;
	localparam logic [2:0] REG_RED_WINDOW   = 3'd2;
	localparam logic [2:0] REG_BLUE_WINDOW  = 3'd3;
	localparam logic [2:0] REG_ACCEPT_MS    = 3'd4;
	localparam logic [2:0] REG_EJECT_MS     = 3'd5;
	localparam logic [2:0] REG_UNJAM_MS     = 3'd6;
	localparam logic [2:0] REG_STALL_SPEED  = 3'd7;

	// Register reset values
	localparam logic [HUE_W-1:0] BLUE_HUE_REF_RST = 9'd220;

	// Intake modes
	localparam logic [MODE_W-1:0] MODE_EJECT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UNJAM  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INTAKE = 2'd2;

	// Roller power presets
	localparam logic signed [POWER_W-1:0] PWR_FWD = 8'sd100;
	localparam logic signed [POWER_W-1:0] PWR_REV = -8'sd100;
	localparam logic signed [POWER_W-1:0] PWR_OFF = 8'sd0;

	// Hue wrap limits
	localparam logic signed [10:0] HUE_HALF = 11'sd180;
	localparam logic signed [10:0] HUE_FULL = 11'sd360;

endpackage

`default_nettype wire

// ===== hw/rtl/color_sort_intake_controller.sv =====
// Top level of the color sort intake controller: input register, decision logic, result register.
//
// The block takes one control tick per item on the s_ channel and returns one result
// item per tick on the m_ channel. An input item carries the time, a hue sample, the
// intake speed (tdata) and the object-near and team flags (tuser). The result item
// carries the intake mode, the three roller powers, the seen block color and the
// accept-window flag.
// An accepted item is registered in the input register, decided from there into the
// result register and shown on m_tvalid from then on. Throughput is one item per cycle
// while the receiver takes the results; the decision for an item and the update of the
// timer state happen in the same cycle, so the next item already sees the new state.
// When the receiver holds m_tready low, the result register keeps its item and the
// input register can still take one more item; after that s_tready drops until the
// result is taken.
// The user writes configuration registers over the APB port only while no item is in flight;
// the block does not enforce this. Reset clears all timers and flags and loads the register
// defaults; the first item after reset sets the block color from its team flag, or from its hue if near.
`default_nettype none

module color_sort_intake_controller
	import csic_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // time_ms[31:0], hue[40:32], intake_speed[47:41]
	input  wire logic [1:0]  s_tuser,   // object_near[0], team_red[1]
	// Result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // mode[1:0], first_power[9:2], middle_power[17:10],
	                                    // last_power[25:18], looks_red[26], accepting[27], zero
	// Configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// Wrapped absolute hue distance, at most 180
	function automatic logic [WIN_W-1:0] hue_dist(logic [HUE_W-1:0] ref_hue,
			logic [HUE_W-1:0] h);
		logic signed [10:0] d;
		logic signed [10:0] w;
		d = $signed({2'b00, ref_hue}) - $signed({2'b00, h});
		if (d > HUE_HALF) begin
			w = d - HUE_FULL;
		end else if (d < -HUE_HALF) begin
			w = d + HUE_FULL;
		end else begin
			w = d;
		end
		if (w < 0) begin
			w = -w;
		end
		return w[WIN_W-1:0];
	endfunction

	// End time, saturated at the largest time value
	function automatic logic [TIME_W-1:0] end_time(logic [TIME_W-1:0] now,
			logic [DUR_W-1:0] dur);
		logic [TIME_W:0] s;
		s = {1'b0, now} + {{(TIME_W+1-DUR_W){1'b0}}, dur};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

	// Configuration registers
	logic [HUE_W-1:0]   red_hue_ref_q, blue_hue_ref_q;
	logic [WIN_W-1:0]   red_window_q, blue_window_q;
	logic [DUR_W-1:0]   accept_ms_q, eject_ms_q, unjam_ms_q;
	logic [SPEED_W-1:0] stall_speed_q;

	// Controller state
	logic              started_q, block_red_q;
	logic              accept_active_q, accept_armed_q, eject_armed_q;
	logic              unjam_armed_q, speed_reached_q;
	logic [TIME_W-1:0] accept_end_q, eject_end_q, unjam_end_q;

	// Pipeline registers
	logic               valid_s1;
	logic [TIME_W-1:0]  time_s1;
	logic [HUE_W-1:0]   hue_s1;
	logic [SPEED_W-1:0] speed_s1;
	logic               near_s1, team_s1;
	logic               valid_s2;
	logic [31:0]        data_s2;

	// Next-state values of the decision logic
	logic              blk_d, acc_active_d, acc_armed_d, ej_armed_d, un_armed_d, spd_d;
	logic [TIME_W-1:0] acc_end_d, ej_end_d, un_end_d;
	logic              sort_done, jam_done, correct, wrong, sees_red, sees_blue;
	logic [WIN_W-1:0]  rd, bd;
	logic [MODE_W-1:0] mode_d;
	logic [POWER_W-1:0] p1_d, p2_d, p3_d;
	logic              advance, cfg_wr;

	// Handshake: the result register frees up when empty or taken
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_hue_ref_q  <= '0;
			blue_hue_ref_q <= BLUE_HUE_REF_RST;
			red_window_q   <= '0;
			blue_window_q  <= '0;
			accept_ms_q    <= '0;
			eject_ms_q     <= '0;
			unjam_ms_q     <= '0;
			stall_speed_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_RED_HUE_REF:  red_hue_ref_q  <= pwdata[HUE_W-1:0];
				REG_BLUE_HUE_REF: blue_hue_ref_q <= pwdata[HUE_W-1:0];
				REG_RED_WINDOW:   red_window_q   <= pwdata[WIN_W-1:0];
				REG_BLUE_WINDOW:  blue_window_q  <= pwdata[WIN_W-1:0];
				REG_ACCEPT_MS:    accept_ms_q    <= pwdata[DUR_W-1:0];
				REG_EJECT_MS:     eject_ms_q     <= pwdata[DUR_W-1:0];
				REG_UNJAM_MS:     unjam_ms_q     <= pwdata[DUR_W-1:0];
				REG_STALL_SPEED:  stall_speed_q  <= pwdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		prdata = '0;
		unique case (paddr[4:2])
			REG_RED_HUE_REF:  prdata = {{(32-HUE_W){1'b0}}, red_hue_ref_q};
			REG_BLUE_HUE_REF: prdata = {{(32-HUE_W){1'b0}}, blue_hue_ref_q};
			REG_RED_WINDOW:   prdata = {{(32-WIN_W){1'b0}}, red_window_q};
			REG_BLUE_WINDOW:  prdata = {{(32-WIN_W){1'b0}}, blue_window_q};
			REG_ACCEPT_MS:    prdata = {{(32-DUR_W){1'b0}}, accept_ms_q};
			REG_EJECT_MS:     prdata = {{(32-DUR_W){1'b0}}, eject_ms_q};
			REG_UNJAM_MS:     prdata = {{(32-DUR_W){1'b0}}, unjam_ms_q};
			REG_STALL_SPEED:  prdata = {{(32-SPEED_W){1'b0}}, stall_speed_q};
			default:          prdata = '0;
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			time_s1  <= s_tdata[31:0];
			hue_s1   <= s_tdata[40:32];
			speed_s1 <= s_tdata[47:41];
			near_s1  <= s_tuser[0];
			team_s1  <= s_tuser[1];
		end
	end

	// Decision logic: color match, the three timers and the mode choice
	always_comb begin
		blk_d        = started_q ? block_red_q : team_s1;
		acc_active_d = accept_active_q;
		acc_armed_d  = accept_armed_q;
		acc_end_d    = accept_end_q;
		ej_armed_d   = eject_armed_q;
		ej_end_d     = eject_end_q;
		un_armed_d   = unjam_armed_q;
		un_end_d     = unjam_end_q;
		spd_d        = speed_reached_q;
		rd           = hue_dist(red_hue_ref_q, hue_s1);
		bd           = hue_dist(blue_hue_ref_q, hue_s1);
		sees_red     = (rd < red_window_q) && (red_window_q != '0);
		sees_blue    = (bd < blue_window_q) && (blue_window_q != '0);
		correct      = 1'b0;
		wrong        = 1'b0;

		// Color of a nearby block; a tie counts as blue
		if (near_s1) begin
			blk_d   = rd < bd;
			correct = team_s1 ? sees_red : sees_blue;
			wrong   = team_s1 ? sees_blue : sees_red;
		end

		// Accept window
		if (correct && !acc_armed_d) begin
			acc_end_d    = end_time(time_s1, accept_ms_q);
			acc_armed_d  = 1'b1;
			acc_active_d = 1'b1;
		end
		if (acc_armed_d) begin
			if (time_s1 < acc_end_d) begin
				acc_active_d = 1'b1;
			end else begin
				acc_armed_d  = 1'b0;
				acc_active_d = 1'b0;
			end
		end

		// Eject period cancels the accept window
		if (wrong && !ej_armed_d) begin
			ej_end_d     = end_time(time_s1, eject_ms_q);
			ej_armed_d   = 1'b1;
			acc_armed_d  = 1'b0;
			acc_active_d = 1'b0;
		end
		sort_done = 1'b1;
		if (ej_armed_d) begin
			if (time_s1 < ej_end_d) begin
				sort_done = 1'b0;
			end else begin
				ej_armed_d = 1'b0;
				un_armed_d = 1'b0;
				spd_d      = 1'b0;
			end
		end

		// Stall detection after speed was reached
		if (acc_active_d && sort_done && (speed_s1 > stall_speed_q)) begin
			spd_d = 1'b1;
		end
		if ((speed_s1 < stall_speed_q) && !un_armed_d && spd_d && sort_done
				&& acc_active_d) begin
			un_end_d   = end_time(time_s1, unjam_ms_q);
			un_armed_d = 1'b1;
			spd_d      = 1'b0;
		end
		jam_done = 1'b1;
		if (un_armed_d) begin
			spd_d = 1'b0;
			if (time_s1 < un_end_d) begin
				jam_done = 1'b0;
			end else begin
				un_armed_d = 1'b0;
			end
		end

		// Mode and roller powers
		if (!sort_done || !acc_active_d) begin
			mode_d = MODE_EJECT;
			p1_d   = PWR_FWD;
			p2_d   = PWR_OFF;
			p3_d   = PWR_REV;
		end else if (!jam_done) begin
			mode_d = MODE_UNJAM;
			p1_d   = PWR_REV;
			p2_d   = PWR_FWD;
			p3_d   = PWR_FWD;
		end else begin
			mode_d = MODE_INTAKE;
			p1_d   = PWR_FWD;
			p2_d   = PWR_OFF;
			p3_d   = PWR_FWD;
		end
	end

	// State update, once per decided item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q       <= 1'b0;
			block_red_q     <= 1'b0;
			accept_active_q <= 1'b0;
			accept_armed_q  <= 1'b0;
			accept_end_q    <= '0;
			eject_armed_q   <= 1'b0;
			eject_end_q     <= '0;
			unjam_armed_q   <= 1'b0;
			unjam_end_q     <= '0;
			speed_reached_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			started_q       <= 1'b1;
			block_red_q     <= blk_d;
			accept_active_q <= acc_active_d;
			accept_armed_q  <= acc_armed_d;
			accept_end_q    <= acc_end_d;
			eject_armed_q   <= ej_armed_d;
			eject_end_q     <= ej_end_d;
			unjam_armed_q   <= un_armed_d;
			unjam_end_q     <= un_end_d;
			speed_reached_q <= spd_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			data_s2 <= {4'b0000, acc_active_d, blk_d, p3_d, p2_d, p1_d, mode_d};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/csic_checker.sv =====
// Port-level checker of the color sort intake controller, bound to the top level.
`default_nettype none

module csic_checker
	import csic_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// A stalled result item stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// The input side only stalls while a result waits on a stalled receiver.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a waiting result");

	// Outside the accept window the block always ejects.
	a_eject_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[27] |-> m_tdata[1:0] == MODE_EJECT)
		else $error("non-eject mode outside the accept window");

	// Roller powers follow the mode.
	a_powers: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			(m_tdata[1:0] == MODE_EJECT && m_tdata[9:2] == PWR_FWD
				&& m_tdata[17:10] == PWR_OFF && m_tdata[25:18] == PWR_REV)
			|| (m_tdata[1:0] == MODE_UNJAM && m_tdata[9:2] == PWR_REV
				&& m_tdata[17:10] == PWR_FWD && m_tdata[25:18] == PWR_FWD)
			|| (m_tdata[1:0] == MODE_INTAKE && m_tdata[9:2] == PWR_FWD
				&& m_tdata[17:10] == PWR_OFF && m_tdata[25:18] == PWR_FWD))
		else $error("roller powers do not match the mode");

endmodule

bind color_sort_intake_controller csic_checker u_csic_checker (.*);

`default_nettype wire

// ===== sim/intake_decision_checker.sv =====
// Checker that predicts and compares the result items of the color sort intake controller.
module intake_decision_checker
	import csic_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // time_ms[31:0], hue[40:32], intake_speed[47:41]
	input  logic [1:0]  s_tuser,   // object_near[0], team_red[1]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // mode[1:0], first_power[9:2], middle_power[17:10],
	                               // last_power[25:18], looks_red[26], accepting[27], zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int          mismatches,
	output int          in_flight
);

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic signed [POWER_W-1:0] first_power;
		logic signed [POWER_W-1:0] middle_power;
		logic signed [POWER_W-1:0] last_power;
		logic                      looks_red;
		logic                      accepting;
	} decision_t;

	// Local copies of the configuration registers
	logic [HUE_W-1:0]   red_hue, blue_hue;
	logic [WIN_W-1:0]   red_win, blue_win;
	logic [DUR_W-1:0]   accept_len, eject_len, unjam_len;
	logic [SPEED_W-1:0] stall_thr;

	// Controller state as the predictor tracks it
	logic              color_red, color_latched;
	logic              acc_active, acc_armed, ej_armed, uj_armed, spd_reached;
	logic [TIME_W-1:0] acc_end, ej_end, uj_end;

	decision_t pending_decisions[$];
	decision_t want, got;

	// End time of a period, held at the largest time when the sum overflows.
	function automatic logic [TIME_W-1:0] deadline(input logic [TIME_W-1:0] now,
			input logic [DUR_W-1:0] dur);
		logic [TIME_W:0] sum;
		sum = {1'b0, now} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur};
		return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	endfunction

	// Distance between two hues, wrapped once around the circle.
	function automatic int hue_distance(input logic [HUE_W-1:0] target,
			input logic [HUE_W-1:0] hue);
		int d;
		d = int'(target) - int'(hue);
		if (d > int'(HUE_HALF)) begin
			d -= int'(HUE_FULL);
		end else if (d < -int'(HUE_HALF)) begin
			d += int'(HUE_FULL);
		end
		return (d < 0) ? -d : d;
	endfunction

	// Advances the timers by one tick and works out the mode and powers it yields.
	function automatic decision_t decide_intake(input logic [TIME_W-1:0] now,
			input logic [HUE_W-1:0] hue, input logic near, input logic [SPEED_W-1:0] speed,
			input logic team);
		decision_t d;
		logic correct, wrong, sees_red, sees_blue, sort_done, jam_done;
		int rd, bd;
		correct = 1'b0;
		wrong = 1'b0;
		if (!color_latched) begin
			color_red = team;
			color_latched = 1'b1;
		end

		// Color match against both references
		if (near) begin
			rd = hue_distance(red_hue, hue);
			bd = hue_distance(blue_hue, hue);
			sees_red = (red_win != 0) && (rd < int'(red_win));
			sees_blue = (blue_win != 0) && (bd < int'(blue_win));
			color_red = (rd < bd);
			correct = team ? sees_red : sees_blue;
			wrong = team ? sees_blue : sees_red;
		end

		// Accept window
		if (correct && !acc_armed) begin
			acc_end = deadline(now, accept_len);
			acc_armed = 1'b1;
			acc_active = 1'b1;
		end
		if (acc_armed) begin
			if (now < acc_end) begin
				acc_active = 1'b1;
			end else begin
				acc_armed = 1'b0;
				acc_active = 1'b0;
			end
		end

		// Eject period, which cancels the accept window
		if (wrong && !ej_armed) begin
			ej_end = deadline(now, eject_len);
			ej_armed = 1'b1;
			acc_armed = 1'b0;
			acc_active = 1'b0;
		end
		if (ej_armed) begin
			if (now < ej_end) begin
				sort_done = 1'b0;
			end else begin
				ej_armed = 1'b0;
				sort_done = 1'b1;
				uj_armed = 1'b0;
				spd_reached = 1'b0;
			end
		end else begin
			sort_done = 1'b1;
		end

		// Stall detection and unjam period
		if (acc_active && sort_done && speed > stall_thr) begin
			spd_reached = 1'b1;
		end
		if (speed < stall_thr && !uj_armed && spd_reached && sort_done && acc_active) begin
			uj_end = deadline(now, unjam_len);
			uj_armed = 1'b1;
			spd_reached = 1'b0;
		end
		if (uj_armed) begin
			spd_reached = 1'b0;
			if (now < uj_end) begin
				jam_done = 1'b0;
			end else begin
				uj_armed = 1'b0;
				jam_done = 1'b1;
			end
		end else begin
			jam_done = 1'b1;
		end

		// Mode and roller powers
		if (!sort_done || !acc_active) begin
			d.mode = MODE_EJECT;
			d.first_power = PWR_FWD;
			d.middle_power = PWR_OFF;
			d.last_power = PWR_REV;
		end else if (!jam_done) begin
			d.mode = MODE_UNJAM;
			d.first_power = PWR_REV;
			d.middle_power = PWR_FWD;
			d.last_power = PWR_FWD;
		end else begin
			d.mode = MODE_INTAKE;
			d.first_power = PWR_FWD;
			d.middle_power = PWR_OFF;
			d.last_power = PWR_FWD;
		end
		d.looks_red = color_red;
		d.accepting = acc_active;
		return d;
	endfunction

	// Track register writes, predict each accepted item and compare each result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_hue = '0;
			blue_hue = BLUE_HUE_REF_RST;
			red_win = '0;
			blue_win = '0;
			accept_len = '0;
			eject_len = '0;
			unjam_len = '0;
			stall_thr = '0;
			color_red = 1'b0;
			color_latched = 1'b0;
			acc_active = 1'b0;
			acc_armed = 1'b0;
			ej_armed = 1'b0;
			uj_armed = 1'b0;
			spd_reached = 1'b0;
			acc_end = '0;
			ej_end = '0;
			uj_end = '0;
			pending_decisions.delete();
			mismatches = 0;
			in_flight = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_RED_HUE_REF:  red_hue = pwdata[HUE_W-1:0];
					REG_BLUE_HUE_REF: blue_hue = pwdata[HUE_W-1:0];
					REG_RED_WINDOW:   red_win = pwdata[WIN_W-1:0];
					REG_BLUE_WINDOW:  blue_win = pwdata[WIN_W-1:0];
					REG_ACCEPT_MS:    accept_len = pwdata[DUR_W-1:0];
					REG_EJECT_MS:     eject_len = pwdata[DUR_W-1:0];
					REG_UNJAM_MS:     unjam_len = pwdata[DUR_W-1:0];
					REG_STALL_SPEED:  stall_thr = pwdata[SPEED_W-1:0];
					default: ;
				endcase
			end

			// Results are checked before this edge's item is queued.
			if (m_tvalid && m_tready) begin
				got.mode = m_tdata[1:0];
				got.first_power = m_tdata[9:2];
				got.middle_power = m_tdata[17:10];
				got.last_power = m_tdata[25:18];
				got.looks_red = m_tdata[26];
				got.accepting = m_tdata[27];
				if (pending_decisions.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result item %h with none expected", $time, m_tdata);
					end
				end else begin
					want = pending_decisions.pop_front();
					if (got.mode !== want.mode || got.first_power !== want.first_power ||
							got.middle_power !== want.middle_power ||
							got.last_power !== want.last_power ||
							got.looks_red !== want.looks_red ||
							got.accepting !== want.accepting) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: expected mode %0d powers %0d/%0d/%0d red %b accepting %b",
								$time, want.mode, want.first_power, want.middle_power,
								want.last_power, want.looks_red, want.accepting);
							$display("%0t:      got mode %0d powers %0d/%0d/%0d red %b accepting %b",
								$time, got.mode, got.first_power, got.middle_power,
								got.last_power, got.looks_red, got.accepting);
						end
					end
				end
			end

			if (s_tvalid && s_tready) begin
				pending_decisions.push_back(decide_intake(s_tdata[31:0], s_tdata[40:32],
					s_tuser[0], s_tdata[47:41], s_tuser[1]));
			end
			in_flight = pending_decisions.size();
		end
	end

endmodule

// ===== sim/color_sort_intake_controller_tb.sv =====
// Testbench top of the color sort intake controller: clock, reset, stimulus and verdict.
module color_sort_intake_controller_tb;
	import csic_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 150;
	localparam int SETTLE = 4;
	localparam int RANDOM_PHASES = 10;
	localparam int TICKS_PER_PHASE = 125;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready;
	logic [47:0] s_tdata;   // time_ms[31:0], hue[40:32], intake_speed[47:41]
	logic [1:0]  s_tuser;   // object_near[0], team_red[1]
	logic        m_tvalid, m_tready;
	logic [31:0] m_tdata;   // mode[1:0], first_power[9:2], middle_power[17:10],
	                        // last_power[25:18], looks_red[26], accepting[27], zero
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;

	int mismatches, in_flight;
	int long_holds_wanted = 0;
	int long_holds_done = 0;

	// Register values of the current phase and the running tick state
	logic [31:0] setting [8];
	logic [31:0] clock_ms;
	logic        our_team_red;

	color_sort_intake_controller uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	intake_decision_checker decision_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.mismatches(mismatches), .in_flight(in_flight)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on cycles in which nothing moves on any port.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Result receiver: runs of steady, sparse and stalled readiness, plus long hold-offs on request.
	initial begin
		int run, pattern;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_holds_done < long_holds_wanted) begin
				@(negedge clk);
				m_tready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_holds_done++;
			end
			pattern = $urandom_range(0, 4);
			run = $urandom_range(1, 30);
			repeat (run) begin
				@(negedge clk);
				case (pattern)
					0, 1: m_tready = 1'b1;
					2: m_tready = 1'($urandom_range(0, 1));
					3: m_tready = ($urandom_range(0, 3) != 0);
					default: m_tready = 1'b0;
				endcase
			end
		end
	end

	// Offers one item and returns at the edge where it is taken.
	task automatic send_tick(input logic [31:0] t, input logic [8:0] hue, input logic near,
			input logic [6:0] speed, input logic team);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {speed, hue, t};
		s_tuser = {team, near};
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	task automatic end_burst();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic program_settings();
		for (int i = 0; i < 8; i++) begin
			apb_write(3'(i), setting[i]);
		end
	endtask

	// Holds the sender until every result has come back and the block has settled.
	task automatic wait_quiet();
		@(negedge clk);
		while (in_flight != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Register value for a phase: flavor 0 gives the floor, 1 the field maximum, else random.
	function automatic logic [31:0] pick_setting(input logic [2:0] idx, input int flavor);
		int roll;
		roll = (flavor == 0) ? 0 : (flavor == 1) ? 1 : $urandom_range(0, 7);
		case (idx)
			REG_RED_HUE_REF, REG_BLUE_HUE_REF:
				case (roll)
					0: return 0;
					1: return 511;
					2: return 359;
					3: return $urandom_range(0, 511);
					default: return $urandom_range(0, 359);
				endcase
			REG_RED_WINDOW, REG_BLUE_WINDOW:
				case (roll)
					0: return 0;
					1: return 255;
					2: return 180;
					default: return $urandom_range(1, 60);
				endcase
			REG_ACCEPT_MS, REG_EJECT_MS, REG_UNJAM_MS:
				case (roll)
					0: return 0;
					1: return 65535;
					default: return $urandom_range(1, 300);
				endcase
			default:
				case (roll)
					0: return 0;
					1: return 127;
					2: return 100;
					default: return $urandom_range(10, 90);
				endcase
		endcase
	endfunction

	// Random tick, mostly near one of the reference hues and around the stall threshold.
	task automatic send_random_tick();
		int roll, target, win, h, thr;
		logic [8:0] hue;
		logic [6:0] speed;
		logic near;

		// Time mostly creeps forward; sometimes it steps back or jumps far.
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			clock_ms = clock_ms - $urandom_range(0, 50);
		end else if (roll < 3) begin
			clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
		end else if (roll < 4) begin
			clock_ms = $urandom;
		end else begin
			clock_ms = clock_ms + $urandom_range(0, 12);
		end
		if ($urandom_range(0, 99) < 3) begin
			our_team_red = ~our_team_red;
		end
		near = ($urandom_range(0, 9) < 7);

		// Hue around our color, the other color, or anywhere
		roll = $urandom_range(0, 99);
		if (roll < 65) begin
			if ((roll < 40) == our_team_red) begin
				target = setting[REG_RED_HUE_REF];
				win = setting[REG_RED_WINDOW];
			end else begin
				target = setting[REG_BLUE_HUE_REF];
				win = setting[REG_BLUE_WINDOW];
			end
			h = $urandom_range(0, win + 2);
			h = ($urandom_range(0, 1) != 0) ? target + h : target - h;
			hue = 9'((h + 1080) % 360);
		end else if (roll < 80) begin
			hue = 9'($urandom_range(0, 511));
		end else begin
			hue = 9'($urandom_range(0, 359));
		end

		// Speed above, below or at the threshold
		thr = setting[REG_STALL_SPEED];
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			speed = (thr >= 127) ? 7'd127
				: 7'($urandom_range(thr + 1, (thr < 100) ? 100 : 127));
		end else if (roll < 70) begin
			speed = (thr == 0) ? 7'd0 : 7'($urandom_range(0, thr - 1));
		end else if (roll < 80) begin
			speed = 7'(thr);
		end else begin
			speed = 7'($urandom_range(0, 127));
		end
		send_tick(clock_ms, hue, near, speed, our_team_red);
	endtask

	// Stimulus and verdict
	initial begin
		int remaining, burst, gap;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Register defaults: no window can match; field extremes and the hue tie.
		send_tick(32'd0, 9'd0, 1'b0, 7'd0, 1'b1);
		send_tick(32'd1, 9'd359, 1'b1, 7'd100, 1'b0);
		send_tick(32'd2, 9'd511, 1'b1, 7'd127, 1'b1);
		send_tick(32'hFFFF_FFFF, 9'd220, 1'b1, 7'd0, 1'b0);
		send_tick(32'd5, 9'd110, 1'b1, 7'd50, 1'b1);
		send_tick(32'd6, 9'd256, 1'b0, 7'd1, 1'b0);
		end_burst();
		wait_quiet();

		// Typical windows: accept, spin-up, stall and unjam, eject, backwards time, saturation.
		setting[REG_RED_HUE_REF] = 10;
		setting[REG_BLUE_HUE_REF] = 220;
		setting[REG_RED_WINDOW] = 30;
		setting[REG_BLUE_WINDOW] = 30;
		setting[REG_ACCEPT_MS] = 100;
		setting[REG_EJECT_MS] = 40;
		setting[REG_UNJAM_MS] = 20;
		setting[REG_STALL_SPEED] = 50;
		program_settings();
		send_tick(32'd1000, 9'd12, 1'b1, 7'd0, 1'b1);
		send_tick(32'd1005, 9'd200, 1'b0, 7'd80, 1'b1);
		send_tick(32'd1010, 9'd200, 1'b0, 7'd50, 1'b1);
		send_tick(32'd1015, 9'd200, 1'b0, 7'd20, 1'b1);
		send_tick(32'd1020, 9'd200, 1'b0, 7'd127, 1'b1);
		send_tick(32'd1040, 9'd200, 1'b0, 7'd60, 1'b1);
		send_tick(32'd1045, 9'd215, 1'b1, 7'd60, 1'b1);
		send_tick(32'd1050, 9'd5, 1'b1, 7'd60, 1'b1);
		send_tick(32'd1090, 9'd5, 1'b0, 7'd60, 1'b1);
		send_tick(32'd1080, 9'd5, 1'b0, 7'd60, 1'b1);
		send_tick(32'hFFFF_FFC0, 9'd12, 1'b1, 7'd60, 1'b1);
		send_tick(32'hFFFF_FFC8, 9'd12, 1'b1, 7'd60, 1'b1);
		send_tick(32'hFFFF_FFFF, 9'd115, 1'b1, 7'd60, 1'b1);
		send_tick(32'hFFFF_FFFF, 9'd511, 1'b1, 7'd0, 1'b0);
		send_tick(32'hFFFF_FFFF, 9'd0, 1'b1, 7'd0, 1'b0);
		end_burst();
		wait_quiet();

		// Widest windows at the extreme references: a hue can match both colors at once.
		setting[REG_RED_HUE_REF] = 0;
		setting[REG_BLUE_HUE_REF] = 359;
		setting[REG_RED_WINDOW] = 180;
		setting[REG_BLUE_WINDOW] = 180;
		setting[REG_ACCEPT_MS] = 65535;
		setting[REG_EJECT_MS] = 0;
		setting[REG_UNJAM_MS] = 65535;
		setting[REG_STALL_SPEED] = 100;
		program_settings();
		send_tick(32'd0, 9'd100, 1'b1, 7'd101, 1'b1);
		send_tick(32'd3, 9'd180, 1'b1, 7'd101, 1'b0);
		send_tick(32'd4, 9'd350, 1'b1, 7'd101, 1'b1);
		send_tick(32'd9, 9'd40, 1'b0, 7'd99, 1'b1);
		end_burst();
		wait_quiet();

		// Random phases, the first two at the floor and the maximum of every register
		clock_ms = 32'd5000;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			for (int i = 0; i < 8; i++) begin
				setting[i] = pick_setting(3'(i), p);
			end
			program_settings();
			our_team_red = 1'($urandom_range(0, 1));
			if (p == 3) begin
				long_holds_wanted++;
			end
			remaining = TICKS_PER_PHASE;
			while (remaining > 0) begin
				burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
				while (burst > 0 && remaining > 0) begin
					send_random_tick();
					burst--;
					remaining--;
				end
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					end_burst();
					repeat (gap - 1) @(negedge clk);
				end
			end
			end_burst();
			wait_quiet();
		end

		if (mismatches == 0 && in_flight == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
